/* rtl/core/mta_pkg.sv */
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types and constants for the mesh tangent accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

  localparam int VertexCountDefault = 4096;
  localparam int IndexWidth = 12;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_TRIANGLE = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_DEGENERATE = 2'd1;
  localparam logic [1:0] ST_SATURATED  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [11:0]        vertex_index;
    logic [11:0]        corner_b;
    logic [11:0]        corner_c;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic [1:0]         status;
  } out_word_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

/* rtl/core/mta_ram.sv */
// ----------------------------------------------------------------------------
// mta_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mta_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/mta_div.sv */
// ----------------------------------------------------------------------------
// mta_div
// Restoring divider, one quotient bit per cycle: q = (n * 2^16 + d/2) / d,
// unsigned 60-bit dividend over 35-bit divisor.
// ----------------------------------------------------------------------------
module mta_div
  import mta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_ctl_t    ctl,
  input  logic [59:0] dividend,
  input  logic [34:0] divisor,
  output logic        busy,
  output logic [59:0] quotient
);
  logic [59:0] num;
  logic [35:0] rem;
  logic [34:0] den;
  logic [5:0]  count;
  logic [35:0] trial;
  logic [35:0] diff;

  assign trial = {rem[34:0], num[59]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      count <= 6'd59;
    end else if (busy) begin
      if (count == 6'd0) busy <= 1'b0;
      count <= count - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!diff[35]) begin
        rem <= diff;
        num <= {num[58:0], 1'b1};
      end else begin
        rem <= trial;
        num <= {num[58:0], 1'b0};
      end
    end
  end

  assign quotient = num;
endmodule

/* rtl/core/mesh_tangent_accumulator_core.sv */
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator_core
// Vertex store with per-triangle tangent accumulation.
//
//   channel | dir | handshake             | word
//   in      | in  | in_valid / in_ready   | in_word_t
//   out     | out | out_valid / out_ready | out_word_t
//
// After the accept edge: load, unused command and a triangle with an index
// out of range go straight to S_OUT; read fetches the tangent sum; a
// degenerate triangle stops after the determinant; a full triangle runs
// three serial divides on the shared divider, each with a fix-up state,
// and three read-modify-write passes on the sum memory; S_OUT sets out_valid.
// Reset clears control only; stores are undefined until loaded.
// A stalled result holds in the output register; the next word is taken
// the cycle after it drains.
// ----------------------------------------------------------------------------
module mesh_tangent_accumulator_core
  import mta_pkg::*;
#(
  parameter int VERTEX_COUNT = VertexCountDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);
  localparam int AW = $clog2(VERTEX_COUNT);

  localparam logic [3:0] S_IDLE = 4'd0, S_RA = 4'd1, S_RB = 4'd2, S_RC = 4'd3,
                         S_DLT = 4'd4, S_DET = 4'd5, S_NUM = 4'd6, S_NUM2 = 4'd7,
                         S_DIV = 4'd8, S_FIX = 4'd9, S_URD = 4'd10, S_UWR = 4'd11,
                         S_OUT = 4'd12, S_RD = 4'd13;
  logic [3:0] state;

  in_word_t cmd;
  logic [AW-1:0] ia, ib, ic;

  // memories: vertex (position and texcoord) and tangent sum
  logic            pos_we, sum_we;
  logic [AW-1:0]   pos_wa, sum_wa, rd_a, sum_ra;
  logic [71:0]     pos_wd, pos_rd;
  logic [31:0]     tex_wd, tex_rd;
  logic [103:0]    vtx_rd;
  logic [95:0]     sum_wd, sum_rd;

  mta_ram #(.Width(104), .Depth(VERTEX_COUNT)) u_vtx (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata({pos_wd, tex_wd}), .raddr(rd_a),
    .rdata(vtx_rd));
  mta_ram #(.Width(96), .Depth(VERTEX_COUNT)) u_sum (
    .clk, .we(sum_we), .waddr(sum_wa), .wdata(sum_wd), .raddr(sum_ra), .rdata(sum_rd));

  assign pos_rd = vtx_rd[103:32];
  assign tex_rd = vtx_rd[31:0];

  // corner data
  logic signed [23:0] p [3][3];
  logic signed [15:0] t [3][2];
  logic [1:0] rcnt;     // corner being read
  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [24:0] e1 [3], e2 [3];
  logic signed [34:0] det;
  logic signed [42:0] num [3];
  logic signed [41:0] m1, m2;
  logic signed [31:0] tan [3];
  logic [1:0] k;        // component counter
  logic sat;
  logic div_busy, div_wait;
  logic [59:0] div_q;
  div_ctl_t div_ctl;
  logic [59:0] div_n;
  logic [34:0] div_d;
  logic [42:0] mag_n;
  logic [34:0] mag_d;
  logic neg;

  mta_div u_div (.clk, .rst, .ctl(div_ctl), .dividend(div_n), .divisor(div_d),
                 .busy(div_busy), .quotient(div_q));

  logic [42:0] numk;
  assign numk  = num[k];
  assign mag_n = numk[42] ? 43'(-numk) : numk;
  assign mag_d = det[34] ? 35'(-det) : det;
  assign div_n = {mag_n, 16'd0} + 60'(mag_d >> 1);
  assign div_d = mag_d;

  // quotient handling: clamp to 2^40, sign, clamp to 32 bits
  logic [40:0] qm;
  logic signed [41:0] qs;
  logic clamp_hi, clamp_lo;
  assign qm = (div_q > 60'h100_0000_0000) ? 41'h100_0000_0000 : div_q[40:0];
  assign qs = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  assign clamp_hi = qs > 42'sd2147483647;
  assign clamp_lo = qs < -42'sd2147483648;

  // saturating sum update
  logic [1:0] upd;
  logic [AW-1:0] upd_a;
  logic signed [32:0] s [3];
  logic [95:0] upd_w;
  logic upd_sat;
  always_comb begin
    upd_sat = 1'b0;
    upd_w = '0;
    for (int j = 0; j < 3; j++) begin
      s[j] = 33'($signed(sum_rd[95-32*j -: 32])) + 33'(tan[j]);
      if (s[j] > 33'sd2147483647) begin
        upd_w[95-32*j -: 32] = 32'h7fff_ffff; upd_sat = 1'b1;
      end else if (s[j] < -33'sd2147483648) begin
        upd_w[95-32*j -: 32] = 32'h8000_0000; upd_sat = 1'b1;
      end else begin
        upd_w[95-32*j -: 32] = s[j][31:0];
      end
    end
  end
  assign upd_a = (upd == 2'd0) ? ia : (upd == 2'd1) ? ib : ic;

  logic idx_ok;
  assign idx_ok = (32'(cmd.vertex_index) < VERTEX_COUNT);
  logic tri_ok;
  assign tri_ok = idx_ok && (32'(cmd.corner_b) < VERTEX_COUNT) &&
                  (32'(cmd.corner_c) < VERTEX_COUNT);

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    rd_a   = ia;
    case (rcnt)
      2'd1:    rd_a = ib;
      2'd2:    rd_a = ic;
      default: rd_a = ia;
    endcase
    sum_ra = (state == S_RD) ? ia : upd_a;
    pos_we = 1'b0;
    sum_we = 1'b0;
    pos_wa = ia;
    pos_wd = {cmd.pos_x, cmd.pos_y, cmd.pos_z};
    tex_wd = {cmd.tex_u, cmd.tex_v};
    sum_wa = ia;
    sum_wd = '0;
    if (state == S_RA && cmd.command == CMD_LOAD && idx_ok) begin
      pos_we = 1'b1;
      sum_we = 1'b1;
    end
    if (state == S_UWR) begin
      sum_we = 1'b1;
      sum_wa = upd_a;
      sum_wd = upd_w;
    end
    div_ctl.start = (state == S_DIV) && !div_wait;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rcnt      <= '0;
      div_wait  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          cmd   <= in_word;
          ia    <= AW'(in_word.vertex_index);
          ib    <= AW'(in_word.corner_b);
          ic    <= AW'(in_word.corner_c);
          rcnt  <= 2'd0;
          state <= S_RA;
        end
        S_RA: begin
          sat <= 1'b0;
          if (cmd.command == CMD_TRIANGLE && tri_ok) begin
            out_word <= '0;
            rcnt  <= 2'd1;
            state <= S_RB;
          end else if (cmd.command == CMD_READ && idx_ok) begin
            out_word <= '0;
            state <= S_RD;
          end else begin
            out_word.tangent_x <= '0;
            out_word.tangent_y <= '0;
            out_word.tangent_z <= '0;
            out_word.status <= (cmd.command == CMD_TRIANGLE) ? ST_DEGENERATE : ST_OK;
            state <= S_OUT;
          end
        end
        S_RD: state <= S_URD; // sum read issued; data at S_URD reused below
        S_RB, S_RC, S_DLT: begin
          // capture data of corner read last cycle
          p[rcnt - 2'd1][0] <= $signed(pos_rd[71:48]);
          p[rcnt - 2'd1][1] <= $signed(pos_rd[47:24]);
          p[rcnt - 2'd1][2] <= $signed(pos_rd[23:0]);
          t[rcnt - 2'd1][0] <= $signed(tex_rd[31:16]);
          t[rcnt - 2'd1][1] <= $signed(tex_rd[15:0]);
          rcnt <= rcnt + 2'd1;
          state <= (state == S_RB) ? S_RC : (state == S_RC) ? S_DLT : S_DET;
        end
        S_DET: begin
          rcnt <= 2'd0;
          du1 <= 17'(t[1][0]) - 17'(t[0][0]);
          dv1 <= 17'(t[1][1]) - 17'(t[0][1]);
          du2 <= 17'(t[2][0]) - 17'(t[0][0]);
          dv2 <= 17'(t[2][1]) - 17'(t[0][1]);
          for (int j = 0; j < 3; j++) begin
            e1[j] <= 25'(p[1][j]) - 25'(p[0][j]);
            e2[j] <= 25'(p[2][j]) - 25'(p[0][j]);
          end
          k <= 2'd0;
          state <= S_NUM;
        end
        S_NUM: begin
          // one pair of products at a time, each followed by its subtraction: det first, then each numerator
          if (k == 2'd0 && !div_wait) begin
            m1 <= 42'(du1 * dv2);
            m2 <= 42'(du2 * dv1);
            div_wait <= 1'b1;
          end else if (div_wait && k == 2'd0) begin
            det <= 35'(m1 - m2);
            div_wait <= 1'b0;
            k <= 2'd1;
          end else begin
            if (det == 35'sd0) begin
              out_word.status <= ST_DEGENERATE;
              state <= S_OUT;
            end else begin
              k <= 2'd0;
              state <= S_NUM2;
            end
          end
        end
        S_NUM2: begin
          if (!div_wait) begin
            m1 <= 42'(dv2 * e1[k]);
            m2 <= 42'(dv1 * e2[k]);
            div_wait <= 1'b1;
          end else begin
            num[k] <= 43'(m1) - 43'(m2);
            div_wait <= 1'b0;
            if (k == 2'd2) begin
              k <= 2'd0;
              state <= S_DIV;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_DIV: begin
          if (!div_wait) begin
            neg <= numk[42] ^ det[34];
            div_wait <= 1'b1;
          end else if (!div_busy && !div_ctl.start) begin
            div_wait <= 1'b0;
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (clamp_hi) begin
            tan[k] <= 32'sh7fff_ffff; sat <= 1'b1;
          end else if (clamp_lo) begin
            tan[k] <= 32'sh8000_0000; sat <= 1'b1;
          end else begin
            tan[k] <= qs[31:0];
          end
          if (k == 2'd2) begin
            upd <= 2'd0;
            state <= S_URD;
          end else begin
            k <= k + 2'd1;
            state <= S_DIV;
          end
        end
        S_URD: begin
          if (cmd.command == CMD_READ) begin
            out_word.tangent_x <= $signed(sum_rd[95:64]);
            out_word.tangent_y <= $signed(sum_rd[63:32]);
            out_word.tangent_z <= $signed(sum_rd[31:0]);
            state <= S_OUT;
          end else begin
            state <= S_UWR;
          end
        end
        S_UWR: begin
          if (upd_sat) sat <= 1'b1;
          if (upd == 2'd2) begin
            if (sat || upd_sat) out_word.status <= ST_SATURATED;
            state <= S_OUT;
          end else begin
            upd <= upd + 2'd1;
            state <= S_URD;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
